// ===== sv/tea_pkg.sv =====
// Package for the TEA block cipher: constants, shared types and the half-round mix function.
// No dependencies; imported by tea_half_round and tea_block_cipher.
`default_nettype none

package tea_pkg;

	localparam int unsigned ROUND_COUNT_DEF = 32;
	localparam logic [31:0] TEA_DELTA = 32'h9E37_79B9;
	localparam int unsigned WORD_W = 32;

	typedef enum logic {
		KIND_ENCRYPT = 1'b0,
		KIND_DECRYPT = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		KEY_WORD0 = 2'd0,
		KEY_WORD1 = 2'd1,
		KEY_WORD2 = 2'd2,
		KEY_WORD3 = 2'd3
	} cfg_idx_t;

	typedef logic [3:0][WORD_W-1:0] key_t;

	typedef struct packed {
		kind_t             kind;
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;
	} stage_t;

	typedef struct packed {
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;
	} result_t;

	function automatic logic [WORD_W-1:0] mix_half(
		input logic [WORD_W-1:0] v,
		input logic [WORD_W-1:0] s,
		input logic [WORD_W-1:0] ka,
		input logic [WORD_W-1:0] kb
	);
		return ((v << 4) + ka) ^ (v + s) ^ ((v >> 5) + kb);
	endfunction

endpackage

`default_nettype wire

// ===== sv/tea_half_round.sv =====
// One registered half-round of TEA: updates one half of the block, for either direction.
// Depends on tea_pkg.
`default_nettype none

module tea_half_round #(
	parameter int unsigned ROUND_COUNT = tea_pkg::ROUND_COUNT_DEF,
	parameter int unsigned ROUND       = 0,
	parameter int unsigned PHASE       = 0
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 en,
	input  wire                 vld_in,
	input  tea_pkg::stage_t     data_in,
	input  tea_pkg::key_t       keys,
	output logic                vld_s1,
	output tea_pkg::stage_t     data_s1
);
	import tea_pkg::*;

	// encrypt round r uses delta*(r+1); decrypt round r uses delta*(ROUND_COUNT-r)
	localparam logic [63:0] PROD_ENC = 64'(TEA_DELTA) * 64'(ROUND + 1);
	localparam logic [63:0] PROD_DEC = 64'(TEA_DELTA) * 64'(ROUND_COUNT - ROUND);
	localparam logic [WORD_W-1:0] SUM_ENC = PROD_ENC[WORD_W-1:0];
	localparam logic [WORD_W-1:0] SUM_DEC = PROD_DEC[WORD_W-1:0];
	localparam logic FIRST_HALF = (PHASE == 0);

	logic              dec;
	logic              upd_a;
	logic [WORD_W-1:0] sum;
	logic [WORD_W-1:0] src;
	logic [WORD_W-1:0] dst;
	logic [WORD_W-1:0] ka;
	logic [WORD_W-1:0] kb;
	logic [WORD_W-1:0] mix;
	logic [WORD_W-1:0] upd;
	stage_t            nxt;

	always_comb begin
		dec   = (data_in.kind == KIND_DECRYPT);
		// encrypt: a then b; decrypt: b then a
		upd_a = (dec != FIRST_HALF);
		sum   = dec ? SUM_DEC : SUM_ENC;
		src   = upd_a ? data_in.b : data_in.a;
		dst   = upd_a ? data_in.a : data_in.b;
		ka    = upd_a ? keys[KEY_WORD0] : keys[KEY_WORD2];
		kb    = upd_a ? keys[KEY_WORD1] : keys[KEY_WORD3];
		mix   = mix_half(src, sum, ka, kb);
		upd   = dec ? (dst - mix) : (dst + mix);
		nxt   = data_in;
		if (upd_a) begin
			nxt.a = upd;
		end else begin
			nxt.b = upd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s1 <= nxt;
		end
	end

endmodule

`default_nettype wire

// ===== sv/tea_block_cipher.sv =====
// TEA block cipher, pipelined: one half-round per stage, 2-entry output queue.
// Depends on tea_pkg and tea_half_round.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_ready  kind, block_left, block_right
//   out      output     out_valid/out_ready  result_left, result_right
//   cfg      input      cfg_we               cfg_index, cfg_data
//
// One block accepted per cycle while the output queue has a free slot; each block passes
// through the 2*ROUND_COUNT half-round stages and then the output queue.
// arst_n clears key words, stage valid bits and queue state.
// The stages advance together while the output queue has a free slot; in_ready
// comes from queue occupancy only, so out_ready has no combinational path to it.
`default_nettype none

module tea_block_cipher #(
	parameter int unsigned ROUND_COUNT = tea_pkg::ROUND_COUNT_DEF
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        cfg_we,
	input  tea_pkg::cfg_idx_t          cfg_index,
	input  wire [tea_pkg::WORD_W-1:0]  cfg_data,
	input  wire                        in_valid,
	output logic                       in_ready,
	input  wire                        kind,
	input  wire [tea_pkg::WORD_W-1:0]  block_left,
	input  wire [tea_pkg::WORD_W-1:0]  block_right,
	output logic                       out_valid,
	input  wire                        out_ready,
	output logic [tea_pkg::WORD_W-1:0] result_left,
	output logic [tea_pkg::WORD_W-1:0] result_right
);
	import tea_pkg::*;

	localparam int unsigned NSTAGE = 2 * ROUND_COUNT;

	key_t    key_q;
	logic    en;
	logic    push;
	logic    pop;
	stage_t  in_data;
	logic    pipe_vld  [NSTAGE+1];
	stage_t  pipe_data [NSTAGE+1];
	result_t fifo_q    [2];
	logic    wr_ptr_q;
	logic    rd_ptr_q;
	logic [1:0] count_q;

	// key registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cfg_we) begin
			key_q[cfg_index] <= cfg_data;
		end
	end

	assign en       = (count_q != 2'd2);
	assign in_ready = en;

	always_comb begin
		in_data.kind = kind_t'(kind);
		in_data.a    = block_left;
		in_data.b    = block_right;
	end

	assign pipe_vld[0]  = in_valid;
	assign pipe_data[0] = in_data;

	for (genvar g = 0; g < NSTAGE; g++) begin : g_stage
		tea_half_round #(
			.ROUND_COUNT (ROUND_COUNT),
			.ROUND       (g / 2),
			.PHASE       (g % 2)
		) u_half (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.vld_in  (pipe_vld[g]),
			.data_in (pipe_data[g]),
			.keys    (key_q),
			.vld_s1  (pipe_vld[g+1]),
			.data_s1 (pipe_data[g+1])
		);
	end

	// output queue: two entries, free slot guaranteed whenever en is high
	assign push = en && pipe_vld[NSTAGE];
	assign pop  = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q].a <= pipe_data[NSTAGE].a;
			fifo_q[wr_ptr_q].b <= pipe_data[NSTAGE].b;
		end
	end

	assign out_valid    = (count_q != 2'd0);
	assign result_left  = fifo_q[rd_ptr_q].a;
	assign result_right = fifo_q[rd_ptr_q].b;

`ifndef SYNTH
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("output queue count out of range");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		pipe_vld[NSTAGE] && count_q == 2'd2 |=> pipe_vld[NSTAGE])
		else $error("finished block dropped while queue full");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(pipe_vld[NSTAGE]) && $stable(pipe_data[NSTAGE]))
		else $error("last stage changed during stall");
`endif

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for tea_block_cipher: encrypt and decrypt requests under several keys,
// with a scoreboard that predicts each result and random idling on both channels.
// Depends on tea_pkg and tea_block_cipher.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import tea_pkg::*;

	localparam int unsigned STALL_LIMIT  = 2000;
	localparam int unsigned SETTLE_TICKS = 2 * ROUND_COUNT_DEF + 16;
	localparam int unsigned PHASES       = 6;
	localparam int unsigned PHASE_BLOCKS = 200;

	class tea_scoreboard;
		logic [WORD_W-1:0] key [4];
		result_t           expected_blocks [$];
		result_t           last_cipher;
		bit                have_cipher;
		int                errors;

		function new();
			foreach (key[i]) key[i] = '0;
			have_cipher = 1'b0;
			errors = 0;
		endfunction

		function void set_key(cfg_idx_t idx, logic [WORD_W-1:0] value);
			key[int'(idx)] = value;
		endfunction

		function logic [WORD_W-1:0] round_term(logic [WORD_W-1:0] v, logic [WORD_W-1:0] s,
				logic [WORD_W-1:0] ka, logic [WORD_W-1:0] kb);
			return ((v << 4) + ka) ^ (v + s) ^ ((v >> 5) + kb);
		endfunction

		function result_t cipher_block(kind_t k, logic [WORD_W-1:0] a, logic [WORD_W-1:0] b);
			logic [WORD_W-1:0] x;
			logic [WORD_W-1:0] y;
			logic [WORD_W-1:0] s;
			result_t           r;
			x = a;
			y = b;
			if (k == KIND_ENCRYPT) begin
				s = '0;
				for (int n = 0; n < ROUND_COUNT_DEF; n++) begin
					s = s + TEA_DELTA;
					x = x + round_term(y, s, key[0], key[1]);
					y = y + round_term(x, s, key[2], key[3]);
				end
			end else begin
				// sum wraps modulo 2^32
				s = WORD_W'(TEA_DELTA * ROUND_COUNT_DEF);
				for (int n = 0; n < ROUND_COUNT_DEF; n++) begin
					y = y - round_term(x, s, key[2], key[3]);
					x = x - round_term(y, s, key[0], key[1]);
					s = s - TEA_DELTA;
				end
			end
			r.a = x;
			r.b = y;
			return r;
		endfunction

		function void note_request(kind_t k, logic [WORD_W-1:0] a, logic [WORD_W-1:0] b);
			result_t r;
			r = cipher_block(k, a, b);
			expected_blocks.push_back(r);
			if (k == KIND_ENCRYPT) begin
				last_cipher = r;
				have_cipher = 1'b1;
			end
		endfunction

		function void check_result(logic [WORD_W-1:0] a, logic [WORD_W-1:0] b);
			result_t e;
			if (expected_blocks.size() == 0) begin
				$error("unexpected result: result_left %h result_right %h", a, b);
				errors++;
				return;
			end
			e = expected_blocks.pop_front();
			if (a !== e.a) begin
				$error("result_left mismatch: expected %h, actual %h", e.a, a);
				errors++;
			end
			if (b !== e.b) begin
				$error("result_right mismatch: expected %h, actual %h", e.b, b);
				errors++;
			end
		endfunction

		function int pending();
			return expected_blocks.size();
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	cfg_idx_t          cfg_index;
	logic [WORD_W-1:0] cfg_data;
	logic              in_valid;
	logic              in_ready;
	kind_t             kind;
	logic [WORD_W-1:0] block_left;
	logic [WORD_W-1:0] block_right;
	logic              out_valid;
	logic              out_ready;
	logic [WORD_W-1:0] result_left;
	logic [WORD_W-1:0] result_right;

	tea_scoreboard sb;
	bit            calm;
	int unsigned   quiet_cycles;

	tea_block_cipher u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.kind         (kind),
		.block_left   (block_left),
		.block_right  (block_right),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_left  (result_left),
		.result_right (result_right)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit take_break();
		return !calm && ($urandom_range(99) < 26);
	endfunction

	task automatic send_block(input kind_t k, input logic [WORD_W-1:0] a,
			input logic [WORD_W-1:0] b);
		while (take_break()) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		kind        <= k;
		block_left  <= a;
		block_right <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_request(k, a, b);
	endtask

	// stop requesting and wait for every outstanding result
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// only called with the pipeline empty
	task automatic set_keys(input logic [WORD_W-1:0] k0, input logic [WORD_W-1:0] k1,
			input logic [WORD_W-1:0] k2, input logic [WORD_W-1:0] k3);
		cfg_we    <= 1'b1;
		cfg_index <= KEY_WORD0;
		cfg_data  <= k0;
		@(posedge clk);
		sb.set_key(KEY_WORD0, k0);
		cfg_index <= KEY_WORD1;
		cfg_data  <= k1;
		@(posedge clk);
		sb.set_key(KEY_WORD1, k1);
		cfg_index <= KEY_WORD2;
		cfg_data  <= k2;
		@(posedge clk);
		sb.set_key(KEY_WORD2, k2);
		cfg_index <= KEY_WORD3;
		cfg_data  <= k3;
		@(posedge clk);
		sb.set_key(KEY_WORD3, k3);
		cfg_we <= 1'b0;
	endtask

	task automatic directed_blocks();
		send_block(KIND_ENCRYPT, 32'h0000_0000, 32'h0000_0000);
		send_block(KIND_DECRYPT, 32'h0000_0000, 32'h0000_0000);
		send_block(KIND_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_block(KIND_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_block(KIND_ENCRYPT, 32'h0000_0000, 32'hFFFF_FFFF);
		send_block(KIND_DECRYPT, 32'h8000_0000, 32'h0000_0001);
		send_block(KIND_DECRYPT, sb.last_cipher.a, sb.last_cipher.b);
		send_block(KIND_ENCRYPT, 32'h0123_4567, 32'h89AB_CDEF);
		drain();
	endtask

	// result monitor, receiver stalls and the stall watchdog
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready)
				sb.check_result(result_left, result_right);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
			out_ready <= !take_break();
		end
	end

	initial begin
		sb           = new();
		calm         = 1'b0;
		quiet_cycles = 0;
		arst_n      <= 1'b0;
		cfg_we      <= 1'b0;
		cfg_index   <= KEY_WORD0;
		cfg_data    <= '0;
		in_valid    <= 1'b0;
		kind        <= KIND_ENCRYPT;
		block_left  <= '0;
		block_right <= '0;
		out_ready   <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// key words still at their reset value here
		directed_blocks();
		set_keys(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		directed_blocks();
		set_keys(32'h0123_4567, 32'h89AB_CDEF, 32'hFEDC_BA98, 32'h7654_3210);
		directed_blocks();

		for (int p = 0; p < PHASES; p++) begin
			if (p == PHASES - 1)
				set_keys(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
			else
				set_keys($urandom, $urandom, $urandom, $urandom);
			calm = (p == 2);
			for (int n = 0; n < PHASE_BLOCKS; n++) begin
				// hold off mid-phase until the pipeline has emptied
				if (p == 3 && n == PHASE_BLOCKS / 2)
					drain();
				// decrypt the most recent ciphertext; under unchanged keys this gives the plaintext back
				if (sb.have_cipher && $urandom_range(3) == 0)
					send_block(KIND_DECRYPT, sb.last_cipher.a, sb.last_cipher.b);
				else
					send_block(kind_t'($urandom_range(1)), $urandom, $urandom);
			end
			drain();
		end
		calm = 1'b0;

		repeat (SETTLE_TICKS) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
